// ----- rtl/hcbd_pkg.sv -----
// hcbd_pkg: types and constants shared by the chunked body decoder modules
// no dependencies
package hcbd_pkg;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;

   localparam int HEX_DIGIT_BITS = 4;

   localparam logic [2:0] ST_ZERO         = 3'd0;
   localparam logic [2:0] ST_NO_SIZE_CRLF = 3'd1;
   localparam logic [2:0] ST_DATA_CUT     = 3'd2;
   localparam logic [2:0] ST_BAD_TRAILER  = 3'd3;
   localparam logic [2:0] ST_NUL          = 3'd4;
   localparam logic [2:0] ST_CLEAN        = 3'd5;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = QPTR_BITS + 1;

   typedef enum logic [5:0] {
      PH_LINE_START = 6'b000001,
      PH_SIZE       = 6'b000010,
      PH_DATA       = 6'b000100,
      PH_TRAIL_CR   = 6'b001000,
      PH_TRAIL_LF   = 6'b010000,
      PH_STOPPED    = 6'b100000
   } hcbd_phase_type;

   // results caused by one request
   typedef struct packed {
      logic       has_data;
      logic       has_end;
      logic [7:0] data_byte;
      logic [2:0] end_status;
   } hcbd_rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hcbd_qstat_type;

   // bit 4 set when the byte is a hex digit, low bits the digit value
   function automatic logic [HEX_DIGIT_BITS:0] hex_decode(input logic [7:0] b);
      logic [HEX_DIGIT_BITS:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ----- rtl/hcbd_front.sv -----
// hcbd_front: accepts body bytes, runs the chunk framing state and
// pushes the results of each request into the queue; uses hcbd_pkg
module hcbd_front
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS   = 24,
   parameter int LENGTH_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_body_byte,
   input  logic                   req_body_end,
   input  hcbd_qstat_type         q_status,
   output logic                   push,
   output hcbd_rec_type           push_rec,
   output logic [LENGTH_BITS-1:0] push_len
);

   hcbd_phase_type         phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in;
   logic                   open_ff, open_in;
   logic                   cr_ff, cr_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [2:0]             reason_ff, reason_in;

   logic                   accept;
   logic                   at_start;
   logic [SIZE_BITS-1:0]   cur_rem;
   logic                   cur_open;
   logic                   cur_cr;
   logic [HEX_DIGIT_BITS:0] hex;
   logic                   hex_sat;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign at_start  = (phase_ff == PH_LINE_START);
   assign cur_rem   = at_start ? '0 : rem_ff;
   assign cur_open  = at_start ? 1'b1 : open_ff;
   assign cur_cr    = at_start ? 1'b0 : cr_ff;
   assign hex       = hex_decode(req_body_byte);
   assign hex_sat   = |cur_rem[SIZE_BITS-1 -: HEX_DIGIT_BITS];

   always_comb begin
      phase_in  = phase_ff;
      rem_in    = rem_ff;
      open_in   = open_ff;
      cr_in     = cr_ff;
      count_in  = count_ff;
      reason_in = reason_ff;
      push_rec  = '0;
      push_len  = count_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_LINE_START, PH_SIZE: begin
               if (at_start && req_body_byte == CHAR_NUL) begin
                  phase_in  = PH_STOPPED;
                  reason_in = ST_NUL;
               end else if (cur_cr && req_body_byte == CHAR_LF) begin
                  cr_in   = 1'b0;
                  open_in = 1'b1;
                  rem_in  = cur_rem;
                  if (cur_rem == '0) begin
                     phase_in  = PH_STOPPED;
                     reason_in = ST_ZERO;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  phase_in = PH_SIZE;
                  cr_in    = (req_body_byte == CHAR_CR);
                  rem_in   = cur_rem;
                  open_in  = cur_open;
                  if (cur_open) begin
                     if (!hex[HEX_DIGIT_BITS]) begin
                        open_in = 1'b0;
                     end else if (hex_sat) begin
                        rem_in = '1;
                     end else begin
                        rem_in = {cur_rem[SIZE_BITS-HEX_DIGIT_BITS-1:0],
                                  hex[HEX_DIGIT_BITS-1:0]};
                     end
                  end
               end
            end
            PH_DATA: begin
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
               push_rec.has_data  = 1'b1;
               push_rec.data_byte = req_body_byte;
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 1'b1;
               end
               if (rem_ff <= SIZE_BITS'(1)) begin
                  phase_in = PH_TRAIL_CR;
               end
            end
            PH_TRAIL_CR: begin
               if (req_body_byte == CHAR_CR) begin
                  phase_in = PH_TRAIL_LF;
               end else begin
                  phase_in  = PH_STOPPED;
                  reason_in = ST_BAD_TRAILER;
               end
            end
            PH_TRAIL_LF: begin
               if (req_body_byte == CHAR_LF) begin
                  phase_in = PH_LINE_START;
                  rem_in   = '0;
                  open_in  = 1'b1;
                  cr_in    = 1'b0;
               end else begin
                  phase_in  = PH_STOPPED;
                  reason_in = ST_BAD_TRAILER;
               end
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase

         push_len = count_in;
         if (req_body_end) begin
            push_rec.has_end = 1'b1;
            unique case (phase_in)
               PH_LINE_START:            push_rec.end_status = ST_CLEAN;
               PH_SIZE:                  push_rec.end_status = ST_NO_SIZE_CRLF;
               PH_DATA:                  push_rec.end_status = ST_DATA_CUT;
               PH_TRAIL_CR, PH_TRAIL_LF: push_rec.end_status = ST_BAD_TRAILER;
               default:                  push_rec.end_status = reason_in;
            endcase
            phase_in  = PH_LINE_START;
            rem_in    = '0;
            open_in   = 1'b1;
            cr_in     = 1'b0;
            count_in  = '0;
            reason_in = ST_CLEAN;
         end
      end
   end

   assign push = accept && (push_rec.has_data || push_rec.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LINE_START;
         rem_ff    <= '0;
         open_ff   <= 1'b1;
         cr_ff     <= 1'b0;
         count_ff  <= '0;
         reason_ff <= ST_CLEAN;
      end else begin
         phase_ff  <= phase_in;
         rem_ff    <= rem_in;
         open_ff   <= open_in;
         cr_ff     <= cr_in;
         count_ff  <= count_in;
         reason_ff <= reason_in;
      end
   end

endmodule

// ----- rtl/hcbd_queue.sv -----
// hcbd_queue: short result queue between the front and back parts
// uses hcbd_pkg
module hcbd_queue
   import hcbd_pkg::*;
#(
   parameter int LENGTH_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hcbd_rec_type           push_rec,
   input  logic [LENGTH_BITS-1:0] push_len,
   input  logic                   pop,
   output hcbd_rec_type           head_rec,
   output logic [LENGTH_BITS-1:0] head_len,
   output hcbd_qstat_type         q_status
);

   hcbd_rec_type           rec_mem [QUEUE_DEPTH];
   logic [LENGTH_BITS-1:0] len_mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_status.empty = (cnt_ff == '0);
   assign q_status.full  = (cnt_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head_rec = rec_mem[rd_ptr_ff];
   assign head_len = len_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         rec_mem[wr_ptr_ff] <= push_rec;
         len_mem[wr_ptr_ff] <= push_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/hcbd_back.sv -----
// hcbd_back: takes queued results apart into single result items and
// holds them in the output register; uses hcbd_pkg
module hcbd_back
   import hcbd_pkg::*;
#(
   parameter int LENGTH_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcbd_rec_type           head_rec,
   input  logic [LENGTH_BITS-1:0] head_len,
   input  hcbd_qstat_type         q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_data_byte,
   output logic [2:0]             rsp_end_status,
   output logic [LENGTH_BITS-1:0] rsp_out_length,
   output logic                   rsp_run_last
);

   logic                   valid_ff, valid_in;
   logic                   done_ff, done_in;
   logic                   kind_ff, kind_in;
   logic [7:0]             data_ff, data_in;
   logic [2:0]             status_ff, status_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   last_ff, last_in;
   logic                   out_load;

   assign out_load = !valid_ff || rsp_ready;

   always_comb begin
      pop       = 1'b0;
      valid_in  = valid_ff;
      done_in   = done_ff;
      kind_in   = kind_ff;
      data_in   = data_ff;
      status_in = status_ff;
      len_in    = len_ff;
      last_in   = last_ff;
      if (out_load) begin
         valid_in = 1'b0;
         if (!q_status.empty) begin
            valid_in = 1'b1;
            len_in   = head_len;
            if (head_rec.has_data && !done_ff) begin
               kind_in   = KIND_DATA;
               data_in   = head_rec.data_byte;
               status_in = ST_ZERO;
               last_in   = !head_rec.has_end;
               if (head_rec.has_end) begin
                  done_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               kind_in   = KIND_END;
               data_in   = '0;
               status_in = head_rec.end_status;
               last_in   = 1'b1;
               done_in   = 1'b0;
               pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_end_status = status_ff;
   assign rsp_out_length = len_ff;
   assign rsp_run_last   = last_ff;

endmodule

// ----- rtl/http_chunked_body_decoder_top.sv -----
// http_chunked_body_decoder_top: chunked transfer body decoder
// uses hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back
//
//   channel | direction | fields
//   req     | in        | body_byte, body_end
//   rsp     | out       | kind, data_byte, end_status, out_length, run_last
//
// one request per cycle while req_ready is high; the front updates the framing state in the cycle
// a byte is taken, and the result passes through the queue into the output register
// a byte that ends a body while data runs gives two results, a data item
// and then an end item, in the output register; the four-entry queue absorbs that
// reset clears framing state, queue and output valid
// req_ready falls only when the queue is full
module http_chunked_body_decoder_top
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS   = 24,
   parameter int LENGTH_BITS = 22
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_body_byte,
   input  logic                   req_body_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_data_byte,
   output logic [2:0]             rsp_end_status,
   output logic [LENGTH_BITS-1:0] rsp_out_length,
   output logic                   rsp_run_last
);

   hcbd_qstat_type         q_status;
   logic                   push;
   hcbd_rec_type           push_rec;
   logic [LENGTH_BITS-1:0] push_len;
   logic                   pop;
   hcbd_rec_type           head_rec;
   logic [LENGTH_BITS-1:0] head_len;

   hcbd_front #(
      .SIZE_BITS   (SIZE_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_body_byte (req_body_byte),
      .req_body_end  (req_body_end),
      .q_status      (q_status),
      .push          (push),
      .push_rec      (push_rec),
      .push_len      (push_len)
   );

   hcbd_queue #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .push_len (push_len),
      .pop      (pop),
      .head_rec (head_rec),
      .head_len (head_len),
      .q_status (q_status)
   );

   hcbd_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_rec       (head_rec),
      .head_len       (head_len),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_end_status (rsp_end_status),
      .rsp_out_length (rsp_out_length),
      .rsp_run_last   (rsp_run_last)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_run_last && rsp_data_byte == 8'h00)
      else $error("malformed end record");

   a_data_then_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_kind && !rsp_run_last
      |=> rsp_valid && rsp_kind)
      else $error("end record did not follow its data result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
